FILE: rtl/core/pstm_pkg.sv
// Package for the polyphonic square tone mixer.
// Holds the item codes, field widths and fixed constants; no dependencies.
package pstm_pkg;

  localparam int OP_W     = 2;
  localparam int NOTE_W   = 7;
  localparam int PERIOD_W = 13;
  localparam int VOL_W    = 7;
  localparam int SAMPLE_W = 16;

  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_NOTE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOAD = 2'd2;

  localparam logic [SAMPLE_W-1:0] VOICE_STEP = 16'd64;
  localparam logic [VOL_W-1:0]    VOL_RESET  = 7'd63;

endpackage

FILE: rtl/core/polyphonic_square_tone_mixer.sv
// Polyphonic square tone mixer top level.
// Voice state lives in two memories with registered reads; depends on pstm_pkg.
//
// A bank of VOICES square-wave voices mixed into one 16-bit sample per tick
// transaction. Note and load transactions each read, then write back, the
// voice entry. A tick holds off the next transaction while the voice memories
// are walked one entry per cycle through their single read port, each phase
// written back in the cycle after its read; then the sum is scaled by volume
// into the output register. A finished sample waits in that register while
// the next transaction is taken; a tick only stalls at its end if the
// previous sample has not been taken. Voice periods must be loaded before
// ticks start. Volume resets to 63 and is written through cfg_we / cfg_wdata;
// the user must write it only while the block is idle; nothing enforces it.
module polyphonic_square_tone_mixer
  import pstm_pkg::*;
#(
  parameter int VOICES      = 128,
  parameter int PERIOD_BITS = 13
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [VOL_W-1:0]           cfg_wdata,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [OP_W-1:0]            op,
  input  logic [NOTE_W-1:0]          note,
  input  logic                       gate,
  input  logic [PERIOD_W-1:0]        period,
  output logic                       sample_valid,
  input  logic                       sample_stall,
  output logic signed [SAMPLE_W-1:0] sample
);

  localparam int AW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CW = AW + 1;
  localparam int PB = PERIOD_BITS;
  localparam logic [CW-1:0] CNT_END  = CW'(VOICES);
  localparam logic [8:0]    VOICES_W = 9'(VOICES);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RMW   = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]          state, state_next;
  logic [VOL_W-1:0]    volume;
  logic [CW-1:0]       cnt, cnt_next;
  logic                p_vld, p_vld_next;
  logic [AW-1:0]       p_addr, p_addr_next;
  logic [SAMPLE_W-1:0] sum, sum_next;
  logic                pend_load;
  logic                pend_gate;
  logic [AW-1:0]       pend_addr;

  logic [PB:0]         st_mem [VOICES];
  logic [PB-1:0]       per_mem [VOICES];
  logic [VOICES-1:0]   st_ok;
  logic [PB:0]         st_rd;
  logic                st_rd_ok;
  logic [PB-1:0]       per_rd;

  logic [AW-1:0]       rd_addr;
  logic                st_we;
  logic [AW-1:0]       st_waddr;
  logic [PB:0]         st_wdata;
  logic                per_we;

  logic                acc;
  logic [8:0]          note_ext;
  logic                note_ok;
  logic [AW-1:0]       n_addr;
  logic [23:0]         period_ext;
  logic [PB-1:0]       per_in;

  logic [PB:0]         st_val;
  logic                en_cur;
  logic [PB-1:0]       ph_cur;
  logic                hit;
  logic [PB:0]         ph_inc;
  logic [PB-1:0]       ph_nx;
  logic                out_free;
  logic [22:0]         prod;

  assign item_stall = (state != S_IDLE);
  assign acc        = item_valid && !item_stall;
  assign note_ext   = 9'(note);
  assign note_ok    = (note_ext < VOICES_W);
  assign n_addr     = note_ext[AW-1:0];
  assign period_ext = 24'(period);
  assign per_in     = period_ext[PB-1:0];

  assign st_val = st_rd_ok ? st_rd : '0;
  assign en_cur = st_val[PB];
  assign ph_cur = st_val[PB-1:0];
  assign hit    = (per_rd != '0) && en_cur && (ph_cur >= (per_rd >> 1));
  assign ph_inc = {1'b0, ph_cur} + (PB+1)'(1);
  assign ph_nx  = ((per_rd == '0) || (ph_inc >= {1'b0, per_rd})) ? '0 : ph_inc[PB-1:0];

  assign out_free = !sample_valid || !sample_stall;
  assign prod     = 23'(sum) * 23'(volume);

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    p_vld_next  = 1'b0;
    p_addr_next = p_addr;
    sum_next    = sum;
    rd_addr     = n_addr;
    st_we       = 1'b0;
    st_waddr    = pend_addr;
    st_wdata    = '0;
    per_we      = 1'b0;
    case (state)
      S_IDLE: begin
        if (acc) begin
          if (op == OP_TICK) begin
            state_next = S_SWEEP;
            cnt_next   = '0;
            sum_next   = '0;
          end else if ((op == OP_NOTE || op == OP_LOAD) && note_ok) begin
            state_next = S_RMW;
            per_we     = (op == OP_LOAD);
          end
        end
      end
      S_RMW: begin
        st_we      = 1'b1;
        st_waddr   = pend_addr;
        st_wdata   = pend_load ? {en_cur, {PB{1'b0}}} : {pend_gate, ph_cur};
        state_next = S_IDLE;
      end
      S_SWEEP: begin
        rd_addr = cnt[AW-1:0];
        if (cnt < CNT_END) begin
          cnt_next    = cnt + CW'(1);
          p_vld_next  = 1'b1;
          p_addr_next = cnt[AW-1:0];
        end
        if (p_vld) begin
          st_we    = 1'b1;
          st_waddr = p_addr;
          st_wdata = {en_cur, ph_nx};
          if (hit) begin
            sum_next = sum + VOICE_STEP;
          end
          if (cnt == CNT_END) begin
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    if (per_we) begin
      per_mem[n_addr] <= per_in;
    end
    st_rd  <= st_mem[rd_addr];
    per_rd <= per_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_ok    <= '0;
      st_rd_ok <= 1'b0;
    end else begin
      st_rd_ok <= st_ok[rd_addr];
      if (st_we) begin
        st_ok[st_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      volume       <= VOL_RESET;
      sample_valid <= 1'b0;
      p_vld        <= 1'b0;
      cnt          <= '0;
    end else begin
      state <= state_next;
      p_vld <= p_vld_next;
      cnt   <= cnt_next;
      if (cfg_we) begin
        volume <= cfg_wdata;
      end
      if (state == S_DONE && out_free) begin
        sample_valid <= 1'b1;
      end else if (sample_valid && !sample_stall) begin
        sample_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_addr <= p_addr_next;
    sum    <= sum_next;
    if (acc) begin
      pend_load <= (op == OP_LOAD);
      pend_gate <= gate;
      pend_addr <= n_addr;
    end
    if (state == S_DONE && out_free) begin
      sample <= signed'(prod[SAMPLE_W-1:0]);
    end
  end

endmodule

FILE: rtl/core/pstm_chk.sv
// Port-level checker for the polyphonic square tone mixer, with its bind.
// Depends on pstm_pkg and the top level polyphonic_square_tone_mixer.
module pstm_chk
  import pstm_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       item_valid,
  input logic                       item_stall,
  input logic [OP_W-1:0]            op,
  input logic                       sample_valid,
  input logic                       sample_stall,
  input logic signed [SAMPLE_W-1:0] sample
);

  logic item_acc;
  assign item_acc = item_valid && !item_stall;

  a_sample_hold: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_stall |=> sample_valid && $stable(sample))
    else $error("stalled sample changed or dropped");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    item_acc && op == OP_TICK |=> item_stall)
    else $error("tick transaction did not hold off the next one");

  a_short_item: assert property (@(posedge clk) disable iff (rst)
    item_acc && (op == OP_NOTE || op == OP_LOAD) |-> ##2 !item_stall)
    else $error("note or load transaction took too long");

  a_sample_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(sample_valid) |-> $past(item_stall))
    else $error("sample appeared without a tick in progress");

endmodule

bind polyphonic_square_tone_mixer pstm_chk u_pstm_chk (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .op           (op),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .sample       (sample)
);
